### rtl/core/incremental_connectivity_matrix_assert.svh
// Assertion macros used by the connectivity matrix checker.
// Each use states one clocked implication; reset low disables the check.
`ifndef INCREMENTAL_CONNECTIVITY_MATRIX_ASSERT_SVH
`define INCREMENTAL_CONNECTIVITY_MATRIX_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ICM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ICM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/icm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_pkg
// Types and constants shared by the connectivity matrix block.
// ----------------------------------------------------------------------------
package icm_pkg;

    localparam int MaxStations = 64;
    localparam int StationW    = 6;
    localparam int CountW      = 7;
    localparam int DataW       = 32;
    localparam int AddrW       = 3;

    localparam logic [CountW-1:0] CountReset = 7'd64;

    // register index, taken from paddr above the byte offset
    localparam logic [AddrW-3:0] RegStationCount = 1'b0;

    typedef enum logic {
        REQ_ADD   = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic wr_en;
        logic clr_all;
    } t_mem_ctl;

endpackage

### rtl/core/icm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_req_if / icm_rsp_if
// Valid/ready channels for requests and results of the connectivity matrix.
// ----------------------------------------------------------------------------
interface icm_req_if;
    import icm_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [StationW-1:0] station_a;
    logic [StationW-1:0] station_b;

    modport source (output valid, output req_type, output station_a, output station_b,
                    input ready);
    modport sink   (input valid, input req_type, input station_a, input station_b,
                    output ready);
endinterface

interface icm_rsp_if;
    logic valid;
    logic ready;
    logic fully_connected;
    logic bad_station;

    modport source (output valid, output fully_connected, output bad_station,
                    input ready);
    modport sink   (input valid, input fully_connected, input bad_station,
                    output ready);
endinterface

### rtl/core/icm_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_row_store
// Reachability row memory, one row per station, with per-row valid bits so a
// clear resets only the valid bits. Reads are registered; invalid rows read zero.
// ----------------------------------------------------------------------------
module icm_row_store #(
    parameter int MAX_STATIONS = icm_pkg::MaxStations,
    localparam int IdxW = $clog2(MAX_STATIONS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  icm_pkg::t_mem_ctl       i_ctl,
    input  logic [IdxW-1:0]         i_raddr,
    input  logic [IdxW-1:0]         i_waddr,
    input  logic [MAX_STATIONS-1:0] i_wdata,
    output logic [MAX_STATIONS-1:0] o_rdata
);
    import icm_pkg::*;

    logic [MAX_STATIONS-1:0] r_mem [MAX_STATIONS];
    logic [MAX_STATIONS-1:0] r_valid;
    logic [MAX_STATIONS-1:0] r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data  <= r_mem[i_raddr];
        r_rd_valid <= r_valid[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr_all) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

### rtl/core/incremental_connectivity_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_connectivity_matrix
// Station reachability matrix with add-line and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: add a line between station_a and station_b,
//   or clear the matrix. o_rsp returns one result per request: fully_connected
//   (every in-use entry set) and bad_station. station_count is written over the
//   APB port at address 0, by the user only while idle; the block does not enforce it.
// Timing:
//   One request at a time. A clear or a rejected add goes straight to the
//   sweep; a valid add first reads the two end rows (states RDA and RDB).
//   The sweep reads the whole row memory, one row read per cycle, merging the
//   union mask and checking each row as it goes. The next request is taken
//   the cycle after the result is registered.
// Reset:
//   Matrix reads as all zero (row valid bits cleared), station_count = 64,
//   no result pending.
// Stall:
//   A result waits in the output register; a finished sweep holds until the
//   register is free, and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module incremental_connectivity_matrix #(
    parameter int MAX_STATIONS = icm_pkg::MaxStations
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    icm_req_if.sink                    i_req,
    icm_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [icm_pkg::AddrW-1:0]  paddr,
    input  logic [icm_pkg::DataW-1:0]  pwdata,
    output logic [icm_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import icm_pkg::*;

    localparam int IdxW = $clog2(MAX_STATIONS);
    localparam int CntW = $clog2(MAX_STATIONS + 1);
    localparam logic [CountW-1:0] MaxCount  = CountW'(MAX_STATIONS);
    localparam logic [CntW-1:0]   LastIssue = CntW'(MAX_STATIONS);
    localparam logic [IdxW-1:0]   LastRow   = IdxW'(MAX_STATIONS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDA  = 5'b00010,
        S_RDB  = 5'b00100,
        S_SCAN = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [CountW-1:0]       r_count;
    logic [IdxW-1:0]         r_a;
    logic [IdxW-1:0]         r_b;
    logic [CountW-1:0]       r_n;
    logic [MAX_STATIONS-1:0] r_live;
    logic [MAX_STATIONS-1:0] r_mask;
    logic                    r_merge_b;
    logic                    r_bad;
    logic                    r_ok;
    logic [CntW-1:0]         r_ridx;
    logic                    r_proc;
    logic [IdxW-1:0]         r_pidx;
    logic                    r_out_valid;
    logic                    r_out_fc;
    logic                    r_out_bad;

    logic [CountW-1:0]       live_cnt;
    logic [MAX_STATIONS-1:0] live_mask;
    logic                    req_acc;
    logic                    req_clear;
    logic                    req_bad;
    logic [MAX_STATIONS-1:0] rdata;
    logic [MAX_STATIONS-1:0] n_row;
    logic                    row_ok;
    logic                    n_ok;
    logic                    scan_done;
    logic                    out_free;
    logic                    out_load;
    logic [IdxW-1:0]         raddr;
    t_mem_ctl                mem_ctl;
    logic                    cfg_wr;
    logic                    cfg_sel;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[AddrW-1:2] == RegStationCount);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign prdata  = cfg_sel ? DataW'(r_count) : '0;

    // ---------------- request decode ----------------
    always_comb begin
        live_cnt = (r_count > MaxCount) ? MaxCount : r_count;
        for (int j = 0; j < MAX_STATIONS; j++) begin
            live_mask[j] = (CountW'(j) < live_cnt);
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && (r_state == S_IDLE);
    assign req_clear   = (i_req.req_type == REQ_CLEAR);
    assign req_bad     = !req_clear &&
                         ((CountW'(i_req.station_a) >= live_cnt) ||
                          (CountW'(i_req.station_b) >= live_cnt));

    // ---------------- row sweep ----------------
    // union mask goes into every row whose own bit is in the mask
    assign n_row     = rdata | (r_mask[r_pidx] ? r_mask : '0);
    assign row_ok    = (CountW'(r_pidx) >= r_n) || ((n_row & r_live) == r_live);
    assign n_ok      = r_ok && (!r_proc || row_ok);
    assign scan_done = (r_state == S_SCAN) && r_proc && (r_pidx == LastRow);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign out_load  = (scan_done || (r_state == S_FIN)) && out_free;

    always_comb begin
        unique case (r_state)
            S_IDLE:  raddr = r_a;
            S_RDA:   raddr = r_a;
            S_RDB:   raddr = r_b;
            S_SCAN:  raddr = r_ridx[IdxW-1:0];
            S_FIN:   raddr = r_a;
            default: raddr = r_a;
        endcase
    end

    assign mem_ctl.wr_en   = (r_state == S_SCAN) && r_proc && r_mask[r_pidx];
    assign mem_ctl.clr_all = req_acc && req_clear;

    icm_row_store #(
        .MAX_STATIONS (MAX_STATIONS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_raddr (raddr),
        .i_waddr (r_pidx),
        .i_wdata (n_row),
        .o_rdata (rdata)
    );

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CountReset;
            r_ridx      <= '0;
            r_proc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_count <= pwdata[CountW-1:0];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_state <= (!req_clear && !req_bad) ? S_RDA : S_SCAN;
                        r_ridx  <= '0;
                        r_proc  <= 1'b0;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_ridx != LastIssue) begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                    r_proc <= (r_ridx != LastIssue);
                    if (scan_done) begin
                        r_state <= out_free ? S_IDLE : S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_a       <= i_req.station_a[IdxW-1:0];
            r_b       <= i_req.station_b[IdxW-1:0];
            r_n       <= live_cnt;
            r_live    <= live_mask;
            r_bad     <= req_bad;
            r_mask    <= '0;
            r_ok      <= 1'b1;
            r_merge_b <= 1'b0;
        end

        if (r_state == S_RDB) begin
            // row a is on the read port now; row b follows next cycle
            r_mask    <= rdata | (MAX_STATIONS'(1) << r_a) | (MAX_STATIONS'(1) << r_b);
            r_merge_b <= 1'b1;
        end

        if (r_state == S_SCAN) begin
            if (r_merge_b) begin
                r_mask    <= r_mask | rdata;
                r_merge_b <= 1'b0;
            end
            r_ok <= n_ok;
            if (r_ridx != LastIssue) begin
                r_pidx <= r_ridx[IdxW-1:0];
            end
        end

        if (out_load) begin
            r_out_fc  <= (r_state == S_FIN) ? r_ok : n_ok;
            r_out_bad <= r_bad;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.fully_connected = r_out_fc;
    assign o_rsp.bad_station     = r_out_bad;

endmodule

### rtl/core/icm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icm_checker
// Port-level checks for the connectivity matrix, bound to the top level.
// ----------------------------------------------------------------------------
`include "incremental_connectivity_matrix_assert.svh"

module icm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_fully_connected,
    input logic i_rsp_bad_station,
    input logic i_pready
);

    // one request in flight: busy right after acceptance
    `ICM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while previous request in flight")

    // ready still low later on, while the sweep runs
    `ICM_ASSERT_SAME(a_busy_two_later, i_clk, i_rst_n, $past(i_req_valid && i_req_ready && i_rst_n, 2) && $past(i_rst_n), !i_req_ready, "ready returned too early after a request")

    // result held while stalled
    `ICM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result dropped under stall")

    `ICM_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_fully_connected) && $stable(i_rsp_bad_station), "result changed under stall")

    // config port never inserts wait states
    `ICM_ASSERT_SAME(a_pready_high, i_clk, i_rst_n, 1'b1, i_pready, "pready deasserted")

endmodule

bind incremental_connectivity_matrix icm_checker u_icm_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_fully_connected (o_rsp.fully_connected),
    .i_rsp_bad_station     (o_rsp.bad_station),
    .i_pready              (pready)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the station connectivity matrix. Add-line and
// clear requests are sent in random bursts over the request channel while
// the result channel stalls on its own pattern. A scoreboard keeps its own
// reach matrix and compares each result against it. station_count is
// rewritten over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
    import icm_pkg::*;

    localparam int RandItems   = 1850;
    localparam int SettleTicks = 80;
    localparam int CycleLimit  = 4000000;

    typedef struct packed {
        logic fully_connected;
        logic bad_station;
    } t_link_result;

    class reach_board;
        bit [MaxStations-1:0] rows [MaxStations];
        logic [CountW-1:0]    count;
        t_link_result         expected_q [$];
        int                   mismatches;

        function new();
            count      = CountReset;
            mismatches = 0;
            foreach (rows[i]) rows[i] = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the local matrix, queue its result
        function void note_request(t_req_kind kind, logic [StationW-1:0] a,
                                   logic [StationW-1:0] b);
            int unsigned          n;
            bit [MaxStations-1:0] live;
            bit [MaxStations-1:0] merged;
            t_link_result         r;
            n = (count > MaxStations) ? MaxStations : count;
            r.bad_station = 1'b0;
            if (kind == REQ_CLEAR) begin
                foreach (rows[i]) rows[i] = '0;
            end else if (a >= n || b >= n) begin
                r.bad_station = 1'b1;
            end else begin
                merged = rows[a] | rows[b] | (64'd1 << a) | (64'd1 << b);
                for (int i = 0; i < MaxStations; i++)
                    if (merged[i]) rows[i] |= merged;
            end
            live = (n >= MaxStations) ? '1 : ((64'd1 << n) - 64'd1);
            r.fully_connected = 1'b1;
            for (int i = 0; i < n; i++)
                if ((rows[i] & live) != live) r.fully_connected = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic fully_connected, logic bad_station);
            t_link_result want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (fully_connected !== want.fully_connected) begin
                $error("fully_connected: expected %0d, actual %0d",
                       want.fully_connected, fully_connected);
                mismatches++;
            end
            if (bad_station !== want.bad_station) begin
                $error("bad_station: expected %0d, actual %0d",
                       want.bad_station, bad_station);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    icm_req_if req_if ();
    icm_rsp_if rsp_if ();

    incremental_connectivity_matrix uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reach_board board;
    int         cycles      = 0;
    int         burst_left  = 0;
    int         items_sent  = 0;
    int         hold_left   = 0;

    initial begin
        board             = new();
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_ADD;
        req_if.station_a  = '0;
        req_if.station_b  = '0;
        rsp_if.ready      = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: free-running, short frequent stalls, or long rare ones
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            case ((cycles / 1500) % 3)
                1: if ($urandom_range(0, 3) == 0) hold_left <= $urandom_range(1, 6);
                2: if ($urandom_range(0, 15) == 0) hold_left <= $urandom_range(20, 80);
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.fully_connected, rsp_if.bad_station);
    end

    task automatic send_item(t_req_kind kind, logic [StationW-1:0] a,
                             logic [StationW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(40, 80);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.station_a <= a;
        req_if.station_b <= b;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(kind, a, b);
        items_sent++;
    endtask

    // stop sending and let the block finish every outstanding request
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    task automatic set_count(logic [CountW-1:0] value);
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {RegStationCount, 2'b00};
        pwdata  <= DataW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CountW-1:0] !== value) begin
            $error("station_count: expected %0d, actual %0d", value, prdata[CountW-1:0]);
            board.mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.count = value;
    endtask

    initial begin
        int unsigned n;
        int unsigned pick;
        int unsigned tmp;
        int unsigned order [MaxStations];

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset count, full range of station numbers
        send_item(REQ_ADD, 6'd0, 6'd63);
        send_item(REQ_ADD, 6'd63, 6'd63);
        send_item(REQ_ADD, 6'd17, 6'd17);
        send_item(REQ_ADD, 6'd0, 6'd17);
        send_item(REQ_CLEAR, 6'd63, 6'd42);   // ends ignored on clear

        set_count(7'd3);
        send_item(REQ_ADD, 6'd0, 6'd3);
        send_item(REQ_ADD, 6'd3, 6'd0);
        send_item(REQ_ADD, 6'd0, 6'd1);
        send_item(REQ_ADD, 6'd2, 6'd2);
        send_item(REQ_ADD, 6'd1, 6'd2);
        send_item(REQ_ADD, 6'd63, 6'd0);      // rejected, matrix stays full

        set_count(7'd0);                      // nothing in use: vacuously full
        send_item(REQ_ADD, 6'd0, 6'd0);
        send_item(REQ_CLEAR, 6'd0, 6'd0);

        set_count(7'd127);                    // clamps to the maximum
        send_item(REQ_ADD, 6'd63, 6'd0);
        send_item(REQ_ADD, 6'd62, 6'd1);

        set_count(7'd1);
        send_item(REQ_ADD, 6'd0, 6'd0);
        send_item(REQ_ADD, 6'd1, 6'd0);

        set_count(7'd2);
        send_item(REQ_ADD, 6'd1, 6'd1);
        send_item(REQ_ADD, 6'd0, 6'd1);

        set_count(7'd64);                     // old rows come back into view
        send_item(REQ_ADD, 6'd2, 6'd3);

        set_count(7'd65);
        send_item(REQ_CLEAR, 6'd21, 6'd42);

        items_sent = 0;
        while (items_sent < RandItems) begin
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       set_count(7'd64);
                    1:       set_count(7'($urandom_range(65, 127)));
                    2:       set_count(7'd0);
                    3:       set_count(7'd1);
                    4:       set_count(7'd2);
                    5, 6:    set_count(7'($urandom_range(3, 12)));
                    default: set_count(7'($urandom_range(13, 63)));
                endcase
            end
            n = (board.count > MaxStations) ? MaxStations : board.count;

            if (n == 0 || $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(5, 25))
                    send_item(($urandom_range(0, 7) == 0) ? REQ_CLEAR : REQ_ADD,
                              6'($urandom), 6'($urandom));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    send_item(REQ_CLEAR, 6'($urandom), 6'($urandom));
                for (int i = 0; i < n; i++) order[i] = i;
                for (int i = n - 1; i > 0; i--) begin
                    pick     = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[pick];
                    order[pick] = tmp;
                end
                if (n == 1)
                    send_item(REQ_ADD, 6'd0, 6'd0);
                // random spanning tree over the live stations, with noise mixed in
                for (int k = 1; k < n; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        case ($urandom_range(0, 5))
                            0: send_item(REQ_CLEAR, 6'($urandom), 6'($urandom));
                            1, 2: begin
                                if (n < MaxStations)
                                    send_item(REQ_ADD, 6'($urandom_range(n, 63)),
                                              6'($urandom_range(0, 63)));
                                else
                                    send_item(REQ_ADD, 6'(order[k - 1]), 6'(order[k - 1]));
                            end
                            3: begin
                                if (n < MaxStations)
                                    send_item(REQ_ADD, 6'($urandom_range(0, 63)),
                                              6'($urandom_range(n, 63)));
                                else
                                    send_item(REQ_ADD, 6'($urandom), 6'($urandom));
                            end
                            default: begin
                                pick = order[$urandom_range(0, k - 1)];
                                send_item(REQ_ADD, 6'(pick), 6'(pick));
                            end
                        endcase
                    end
                    pick = order[$urandom_range(0, k - 1)];
                    if ($urandom_range(0, 1) != 0)
                        send_item(REQ_ADD, 6'(order[k]), 6'(pick));
                    else
                        send_item(REQ_ADD, 6'(pick), 6'(order[k]));
                end
                repeat ($urandom_range(1, 4))
                    send_item(REQ_ADD, 6'($urandom_range(0, n - 1)),
                              6'($urandom_range(0, n - 1)));
            end
        end

        settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
